[rtl/gravity_magnetic_rotation_matrix_top_assert.svh]
// assertion macros used by the top level rtl of the rotation matrix block
`ifndef GRAVITY_MAGNETIC_ROTATION_MATRIX_TOP_ASSERT_SVH
`define GRAVITY_MAGNETIC_ROTATION_MATRIX_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define GMR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define GMR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gmr_pkg.sv]
// shared types, constants and rounding helper of the rotation matrix block
`timescale 1ns / 1ps
`default_nettype none
package gmr_pkg;
  localparam int DW        = 32;
  localparam int HW        = 2 * DW;
  localparam int FRAC      = 30;
  localparam int NORM_MSB  = 29;
  localparam int ROOT_W    = 31;
  localparam int QUO_W     = 32;
  localparam int CFG_W     = 24;
  localparam int THR_SHIFT = 15;

  localparam logic [CFG_W-1:0] THR_RESET = 24'd6554;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t ONE_Q30     = 32'sh4000_0000;
  localparam word_t NEG_ONE_Q30 = -32'sh4000_0000;
  localparam logic signed [HW-1:0] HALF_Q30 = 64'sd536870912;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    logic vld;
    logic ok;
    vec_t q;
  } uv_res_t;

  // q4.60 to q2.30, round half up, clamp to +-1
  function automatic word_t rnd_sat(input logic signed [HW-1:0] x);
    logic signed [HW-1:0] y;
    y = (x + HALF_Q30) >>> FRAC;
    if (y > HW'(ONE_Q30)) begin
      return ONE_Q30;
    end else if (y < HW'(NEG_ONE_Q30)) begin
      return NEG_ONE_Q30;
    end else begin
      return y[DW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

[rtl/gmr_ifs.sv]
// valid/ready channel interfaces for sample pairs and matrix results
`timescale 1ns / 1ps
`default_nettype none
interface gmr_in_if;
  import gmr_pkg::*;
  logic  valid;
  logic  ready;
  word_t grav_x;
  word_t grav_y;
  word_t grav_z;
  word_t mag_x;
  word_t mag_y;
  word_t mag_z;
  modport source (output valid, grav_x, grav_y, grav_z, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, grav_x, grav_y, grav_z, mag_x, mag_y, mag_z, output ready);
endinterface

interface gmr_out_if;
  import gmr_pkg::*;
  logic  valid;
  logic  ready;
  word_t rot_00;
  word_t rot_01;
  word_t rot_02;
  word_t rot_10;
  word_t rot_11;
  word_t rot_12;
  word_t rot_20;
  word_t rot_21;
  word_t rot_22;
  word_t incl_cos;
  word_t incl_sin;
  logic  valid_res;
  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, incl_cos, incl_sin, valid_res, input ready);
  modport sink   (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, incl_cos, incl_sin, valid_res, output ready);
endinterface
`default_nettype wire

[rtl/gmr_unitvec.sv]
// pipelined block normalization, integer square root and divide to a q2.30 unit vector
`timescale 1ns / 1ps
`default_nettype none
module gmr_unitvec #(
  parameter int W = gmr_pkg::HW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld_in,
  input  logic signed [W-1:0]         v_in [3],
  input  logic [gmr_pkg::CFG_W-1:0]   thr,
  output gmr_pkg::uv_res_t            res
);
  import gmr_pkg::*;

  localparam int KW   = 8;
  localparam int AW   = FRAC + 1;
  localparam int SW   = 2 * ROOT_W;
  localparam int REMW = ROOT_W + 4;
  localparam int NUMW = AW + FRAC;
  localparam int DRW  = ROOT_W + 1;
  localparam int TW   = 72;

  // stage 1: largest magnitude
  logic [W-1:0]        mg [3];
  logic [W-1:0]        mx;
  logic signed [W-1:0] v1 [3];
  logic [W-1:0]        m1;
  logic                vld1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i] = v_in[i][W-1] ? W'(-v_in[i]) : W'(v_in[i]);
    end
    mx = mg[0];
    for (int i = 1; i < 3; i++) begin
      if (mg[i] > mx) mx = mg[i];
    end
  end

  // stage 2: block exponent
  logic [KW-1:0]        pos;
  logic signed [W-1:0]  v2 [3];
  logic signed [KW-1:0] k2;
  logic                 nz2;
  logic                 vld2;

  always_comb begin
    pos = '0;
    for (int j = 0; j < W; j++) begin
      if (m1[j]) pos = KW'(j);
    end
  end

  // stage 3: scaled components
  logic [KW-1:0]        ksh;
  logic signed [W-1:0]  wv [3];
  logic [DW-1:0]        w32 [3];
  logic [DW-1:0]        wneg [3];
  logic [AW-1:0]        a3 [3];
  logic                 sg3 [3];
  logic signed [KW-1:0] k3;
  logic                 nz3;
  logic                 vld3;

  always_comb begin
    ksh = k2[KW-1] ? KW'(-k2) : KW'(k2);
    for (int i = 0; i < 3; i++) begin
      wv[i]   = k2[KW-1] ? (v2[i] <<< ksh) : (v2[i] >>> ksh);
      w32[i]  = wv[i][DW-1:0];
      wneg[i] = -w32[i];
    end
  end

  // stage 4: squares
  logic [SW-1:0]        sq4 [3];
  logic [AW-1:0]        a4 [3];
  logic                 sg4 [3];
  logic signed [KW-1:0] k4;
  logic                 nz4;
  logic                 vld4;

  // square root digit stages, entry 0 holds the sum of squares
  logic [SW-1:0]        is_s    [0:ROOT_W];
  logic [ROOT_W-1:0]    root    [0:ROOT_W];
  logic [REMW-1:0]      rem     [0:ROOT_W];
  logic [AW-1:0]        is_a    [0:ROOT_W][3];
  logic                 is_sg   [0:ROOT_W][3];
  logic signed [KW-1:0] is_k    [0:ROOT_W];
  logic                 is_nz   [0:ROOT_W];
  logic                 is_vld  [0:ROOT_W];
  logic [REMW-1:0]      cand      [1:ROOT_W];
  logic [REMW-1:0]      trial     [1:ROOT_W];
  logic [REMW-1:0]      rem_next  [1:ROOT_W];
  logic [ROOT_W-1:0]    root_next [1:ROOT_W];

  always_comb begin
    for (int i = 1; i <= ROOT_W; i++) begin
      cand[i]  = {rem[i-1][REMW-3:0], is_s[i-1][2*(ROOT_W-i) +: 2]};
      trial[i] = REMW'({root[i-1], 2'b01});
      if (cand[i] >= trial[i]) begin
        rem_next[i]  = cand[i] - trial[i];
        root_next[i] = {root[i-1][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[i]  = cand[i];
        root_next[i] = {root[i-1][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // divide setup and threshold test
  logic [ROOT_W-1:0] n0;
  logic [NUMW-1:0]   num0 [3];
  logic [KW-1:0]     kabs;
  logic [TW-1:0]     tq;
  logic              below;

  always_comb begin
    n0   = root[ROOT_W];
    kabs = is_k[ROOT_W][KW-1] ? KW'(-is_k[ROOT_W]) : KW'(is_k[ROOT_W]);
    tq   = TW'(thr) << THR_SHIFT;
    if (!is_k[ROOT_W][KW-1]) begin
      below = (TW'(n0) << kabs) < tq;
    end else begin
      below = TW'(n0) < (tq << kabs);
    end
    for (int c = 0; c < 3; c++) begin
      num0[c] = {is_a[ROOT_W][c], FRAC'(0)} + NUMW'(n0 >> 1);
    end
  end

  // restoring divide stages, entry 0 holds the setup
  logic [NUMW-1:0]   dnum  [0:QUO_W][3];
  logic [DRW-1:0]    drem  [0:QUO_W][3];
  logic [QUO_W-1:0]  dq    [0:QUO_W][3];
  logic              dsg   [0:QUO_W][3];
  logic [ROOT_W-1:0] dn    [0:QUO_W];
  logic              dok   [0:QUO_W];
  logic              dvld  [0:QUO_W];
  logic [DRW:0]      dc        [1:QUO_W][3];
  logic [DRW-1:0]    drem_next [1:QUO_W][3];
  logic [QUO_W-1:0]  dq_next   [1:QUO_W][3];

  always_comb begin
    for (int j = 1; j <= QUO_W; j++) begin
      for (int c = 0; c < 3; c++) begin
        dc[j][c] = {drem[j-1][c], dnum[j-1][c][QUO_W-j]};
        if (dc[j][c] >= (DRW+1)'(dn[j-1])) begin
          drem_next[j][c] = DRW'(dc[j][c] - (DRW+1)'(dn[j-1]));
          dq_next[j][c]   = {dq[j-1][c][QUO_W-2:0], 1'b1};
        end else begin
          drem_next[j][c] = dc[j][c][DRW-1:0];
          dq_next[j][c]   = {dq[j-1][c][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // clamp and sign
  logic [QUO_W-1:0] qc [3];
  word_t            qf [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qc[c] = (dq[QUO_W][c] > QUO_W'(ONE_Q30)) ? QUO_W'(ONE_Q30) : dq[QUO_W][c];
      qf[c] = dsg[QUO_W][c] ? -$signed(qc[c]) : $signed(qc[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      for (int i = 0; i <= ROOT_W; i++) is_vld[i] <= 1'b0;
      for (int j = 0; j <= QUO_W; j++) dvld[j] <= 1'b0;
      res.vld <= 1'b0;
    end else if (en) begin
      vld1 <= vld_in;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      is_vld[0] <= vld4;
      for (int i = 1; i <= ROOT_W; i++) is_vld[i] <= is_vld[i-1];
      dvld[0] <= is_vld[ROOT_W];
      for (int j = 1; j <= QUO_W; j++) dvld[j] <= dvld[j-1];
      res.vld <= dvld[QUO_W];
    end
    if (en) begin
      v1 <= v_in;
      m1 <= mx;
      v2  <= v1;
      k2  <= $signed(pos) - KW'(NORM_MSB);
      nz2 <= |m1;
      for (int i = 0; i < 3; i++) begin
        a3[i]  <= w32[i][DW-1] ? wneg[i][AW-1:0] : w32[i][AW-1:0];
        sg3[i] <= w32[i][DW-1];
        sq4[i] <= SW'(a3[i]) * SW'(a3[i]);
      end
      k3  <= k2;
      nz3 <= nz2;
      a4  <= a3;
      sg4 <= sg3;
      k4  <= k3;
      nz4 <= nz3;
      is_s[0]  <= sq4[0] + sq4[1] + sq4[2];
      root[0]  <= '0;
      rem[0]   <= '0;
      is_a[0]  <= a4;
      is_sg[0] <= sg4;
      is_k[0]  <= k4;
      is_nz[0] <= nz4;
      for (int i = 1; i <= ROOT_W; i++) begin
        is_s[i]  <= is_s[i-1];
        root[i]  <= root_next[i];
        rem[i]   <= rem_next[i];
        is_a[i]  <= is_a[i-1];
        is_sg[i] <= is_sg[i-1];
        is_k[i]  <= is_k[i-1];
        is_nz[i] <= is_nz[i-1];
      end
      dn[0]  <= n0;
      dok[0] <= is_nz[ROOT_W] && !below;
      for (int c = 0; c < 3; c++) begin
        dnum[0][c] <= num0[c];
        drem[0][c] <= DRW'(num0[c] >> QUO_W);
        dq[0][c]   <= '0;
        dsg[0][c]  <= is_sg[ROOT_W][c];
      end
      for (int j = 1; j <= QUO_W; j++) begin
        dn[j]  <= dn[j-1];
        dok[j] <= dok[j-1];
        for (int c = 0; c < 3; c++) begin
          dnum[j][c] <= dnum[j-1][c];
          drem[j][c] <= drem_next[j][c];
          dq[j][c]   <= dq_next[j][c];
          dsg[j][c]  <= dsg[j-1][c];
        end
      end
      res.ok  <= dok[QUO_W];
      res.q.x <= qf[0];
      res.q.y <= qf[1];
      res.q.z <= qf[2];
    end
  end
endmodule
`default_nettype wire

[rtl/gravity_magnetic_rotation_matrix_top.sv]
// top level: tilt compensated compass rotation matrix pipeline
//
// channel     dir  handshake            payload
// sample      in   sample.valid/ready   grav_x..z, mag_x..z (signed q16.16)
// result      out  result.valid/ready   rot_00..rot_22, incl_cos/sin (q2.30), valid_res
// cfg         in   cfg_we               cfg_wdata = min_horizontal_norm (q16.16)
//
// one item enters per cycle while the pipeline is not frozen; each item passes c1, c2, the
// unit vector blocks (31 square root digit, 32 divide stages), d1..d3 and the output register
// rst clears the valid bit of every stage and loads the threshold with its default
// when the output register holds an item that is not taken, the whole pipeline freezes
// and sample.ready drops in the same cycle; nothing is dropped or repeated
`timescale 1ns / 1ps
`default_nettype none
`include "gravity_magnetic_rotation_matrix_top_assert.svh"
module gravity_magnetic_rotation_matrix_top (
  input  logic                      clk,
  input  logic                      rst,
  gmr_in_if.sink                    sample,
  gmr_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [gmr_pkg::CFG_W-1:0] cfg_wdata
);
  import gmr_pkg::*;

  // threshold register
  logic [CFG_W-1:0] min_horizontal_norm;

  // global advance: output register empty or being drained
  logic en;
  logic res_vld;

  assign en           = !res_vld || result.ready;
  assign sample.ready = en;

  // c1: cross product partial products
  logic signed [HW-1:0] p1 [6];
  word_t                ga1 [3];
  word_t                ma1 [3];
  logic                 vld_c1;

  // c2: horizontal vector h = mag x grav, each product halved with floor
  logic signed [HW-1:0] h2 [3];
  word_t                ga2 [3];
  word_t                ma2 [3];
  logic                 vld_c2;

  // unit vectors for h, gravity and magnetic field
  uv_res_t hres;
  uv_res_t ares;
  uv_res_t eres;

  gmr_unitvec #(.W(HW)) u_h (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (vld_c2),
    .v_in   (h2),
    .thr    (min_horizontal_norm),
    .res    (hres)
  );

  gmr_unitvec #(.W(DW)) u_a (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (vld_c2),
    .v_in   (ga2),
    .thr    ('0),
    .res    (ares)
  );

  gmr_unitvec #(.W(DW)) u_e (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (vld_c2),
    .v_in   (ma2),
    .thr    ('0),
    .res    (eres)
  );

  // d1: products for m = a x h and for e.a
  logic signed [HW-1:0] mp1 [6];
  logic signed [HW-1:0] sp1 [3];
  vec_t                 hu1, au1, eu1;
  logic                 ok1;
  logic                 vld_d1;

  // d2: m row and inclination sine
  vec_t  hu2, au2, eu2, mv2;
  word_t isin2;
  logic  ok2;
  logic  vld_d2;

  // d3: products for e.m
  logic signed [HW-1:0] cp3 [3];
  vec_t                 hu3, au3, mv3;
  word_t                isin3;
  logic                 ok3;
  logic                 vld_d3;

  // output register, zeroed when the item is invalid
  vec_t  o_h, o_m, o_a;
  word_t o_cos, o_sin;
  logic  o_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_horizontal_norm <= THR_RESET;
      vld_c1  <= 1'b0;
      vld_c2  <= 1'b0;
      vld_d1  <= 1'b0;
      vld_d2  <= 1'b0;
      vld_d3  <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      if (cfg_we) min_horizontal_norm <= cfg_wdata;
      if (en) begin
        vld_c1  <= sample.valid;
        vld_c2  <= vld_c1;
        vld_d1  <= hres.vld;
        vld_d2  <= vld_d1;
        vld_d3  <= vld_d2;
        res_vld <= vld_d3;
      end
    end
    if (en) begin
      p1[0] <= sample.mag_y * sample.grav_z;
      p1[1] <= sample.mag_z * sample.grav_y;
      p1[2] <= sample.mag_z * sample.grav_x;
      p1[3] <= sample.mag_x * sample.grav_z;
      p1[4] <= sample.mag_x * sample.grav_y;
      p1[5] <= sample.mag_y * sample.grav_x;
      ga1[0] <= sample.grav_x;
      ga1[1] <= sample.grav_y;
      ga1[2] <= sample.grav_z;
      ma1[0] <= sample.mag_x;
      ma1[1] <= sample.mag_y;
      ma1[2] <= sample.mag_z;

      for (int i = 0; i < 3; i++) begin
        h2[i] <= (p1[2*i] >>> 1) - (p1[2*i+1] >>> 1);
      end
      ga2 <= ga1;
      ma2 <= ma1;

      mp1[0] <= ares.q.y * hres.q.z;
      mp1[1] <= ares.q.z * hres.q.y;
      mp1[2] <= ares.q.z * hres.q.x;
      mp1[3] <= ares.q.x * hres.q.z;
      mp1[4] <= ares.q.x * hres.q.y;
      mp1[5] <= ares.q.y * hres.q.x;
      sp1[0] <= eres.q.x * ares.q.x;
      sp1[1] <= eres.q.y * ares.q.y;
      sp1[2] <= eres.q.z * ares.q.z;
      hu1 <= hres.q;
      au1 <= ares.q;
      eu1 <= eres.q;
      ok1 <= hres.ok && ares.ok && eres.ok;

      mv2.x <= rnd_sat(mp1[0] - mp1[1]);
      mv2.y <= rnd_sat(mp1[2] - mp1[3]);
      mv2.z <= rnd_sat(mp1[4] - mp1[5]);
      isin2 <= rnd_sat(sp1[0] + sp1[1] + sp1[2]);
      hu2 <= hu1;
      au2 <= au1;
      eu2 <= eu1;
      ok2 <= ok1;

      cp3[0] <= eu2.x * mv2.x;
      cp3[1] <= eu2.y * mv2.y;
      cp3[2] <= eu2.z * mv2.z;
      hu3   <= hu2;
      au3   <= au2;
      mv3   <= mv2;
      isin3 <= isin2;
      ok3   <= ok2;

      o_h   <= ok3 ? hu3 : '0;
      o_m   <= ok3 ? mv3 : '0;
      o_a   <= ok3 ? au3 : '0;
      o_sin <= ok3 ? isin3 : '0;
      o_cos <= ok3 ? rnd_sat(cp3[0] + cp3[1] + cp3[2]) : '0;
      o_ok  <= ok3;
    end
  end

  assign result.valid     = res_vld;
  assign result.rot_00    = o_h.x;
  assign result.rot_01    = o_h.y;
  assign result.rot_02    = o_h.z;
  assign result.rot_10    = o_m.x;
  assign result.rot_11    = o_m.y;
  assign result.rot_12    = o_m.z;
  assign result.rot_20    = o_a.x;
  assign result.rot_21    = o_a.y;
  assign result.rot_22    = o_a.z;
  assign result.incl_cos  = o_cos;
  assign result.incl_sin  = o_sin;
  assign result.valid_res = o_ok;

  // a full, blocked output register must hold off new items
  `GMR_ASSERT_IMPL(a_stall_holds_input, result.valid && !result.ready, !sample.ready, "item accepted while output blocked")
  // an accepted item shows up in the first pipeline stage
  `GMR_ASSERT_NEXT(a_accept_enters, sample.valid && sample.ready, vld_c1, "accepted item lost at entry")
  // invalid results carry zeros
  `GMR_ASSERT_IMPL(a_invalid_zero, result.valid && !result.valid_res, result.rot_00 == 0 && result.incl_cos == 0 && result.rot_22 == 0, "invalid result not zeroed")
  // a valid gravity row is nonzero and its z entry lies within +-1
  `GMR_ASSERT_IMPL(a_grav_row_unit, result.valid && result.valid_res, (result.rot_20 != 0 || result.rot_21 != 0 || result.rot_22 != 0) && result.rot_22 <= ONE_Q30 && result.rot_22 >= NEG_ONE_Q30, "gravity row out of range")
endmodule
`default_nettype wire

[bench/gmr_checker.sv]
// checker: watches the sample and result channels, predicts each matrix and compares
`timescale 1ns / 1ps
module gmr_checker (
  input  logic             clk,
  input  logic             rst,
  gmr_in_if.sink           sample,
  gmr_out_if.sink          result,
  input  logic             cfg_we,
  input  logic [23:0]      cfg_wdata,
  output int               fail_count,
  output int               pending
);
  import gmr_pkg::*;

  typedef struct packed {
    word_t [10:0] v;
    logic         vr;
  } matrix_t;

  matrix_t     matrix_q[$];
  logic [23:0] min_norm;

  string field_name [11] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                             "rot_20", "rot_21", "rot_22", "incl_cos", "incl_sin"};

  function automatic logic signed [63:0] fdiv(logic signed [63:0] x, int s);
    return x >>> s;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic [63:0] root(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clamp_round(logic signed [63:0] x);
    logic signed [63:0] y;
    y = (x + 64'sd536870912) >>> 30;
    if (y > 64'sd1073741824) return 64'sd1073741824;
    if (y < -64'sd1073741824) return -64'sd1073741824;
    return y;
  endfunction

  // block normalize to a q2.30 unit vector; returns 0 for the zero vector
  function automatic logic unit_of(input logic signed [63:0] v[3],
                                   output logic signed [63:0] q[3],
                                   output int k, output logic [63:0] n);
    logic [63:0] m, s, a, r;
    logic signed [63:0] w[3];
    m = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin m = m >> 1; k++; end
    while (m < (64'd1 << 29)) begin m = m << 1; k--; end
    for (int i = 0; i < 3; i++) begin
      w[i] = (k > 0) ? fdiv(v[i], k) : (v[i] <<< (-k));
      a = mag(w[i]);
      s += a * a;
    end
    n = root(s);
    for (int i = 0; i < 3; i++) begin
      a = mag(w[i]);
      r = ((a << 30) + (n >> 1)) / n;
      if (r > 64'd1073741824) r = 64'd1073741824;
      q[i] = w[i] < 0 ? -$signed(r) : $signed(r);
    end
    return 1'b1;
  endfunction

  function automatic logic too_short(logic [63:0] n, int k, logic [23:0] thr);
    logic [63:0] t;
    t = {40'd0, thr} << 15;
    if (k >= 0) return (k > 32) ? 1'b0 : ((n << k) < t);
    if ((t >> (63 - (-k))) != 0) return 1'b1;
    return n < (t << (-k));
  endfunction

  function automatic matrix_t predict_matrix(logic signed [63:0] a[3],
                                             logic signed [63:0] e[3], logic [23:0] thr);
    logic signed [63:0] h[3], hn[3], an[3], en[3], mv[3];
    logic signed [63:0] ic, is;
    logic [63:0] n;
    int k;
    logic ok;
    matrix_t res;
    res = '0;
    h[0] = fdiv(e[1] * a[2], 1) - fdiv(e[2] * a[1], 1);
    h[1] = fdiv(e[2] * a[0], 1) - fdiv(e[0] * a[2], 1);
    h[2] = fdiv(e[0] * a[1], 1) - fdiv(e[1] * a[0], 1);
    ok = unit_of(h, hn, k, n);
    if (ok) ok = !too_short(n, k, thr);
    if (ok) ok = unit_of(a, an, k, n);
    if (ok) ok = unit_of(e, en, k, n);
    if (!ok) return res;
    mv[0] = clamp_round(an[1] * hn[2] - an[2] * hn[1]);
    mv[1] = clamp_round(an[2] * hn[0] - an[0] * hn[2]);
    mv[2] = clamp_round(an[0] * hn[1] - an[1] * hn[0]);
    for (int i = 0; i < 3; i++) begin
      res.v[i] = hn[i][31:0];
      res.v[3 + i] = mv[i][31:0];
      res.v[6 + i] = an[i][31:0];
    end
    ic = clamp_round(en[0] * mv[0] + en[1] * mv[1] + en[2] * mv[2]);
    is = clamp_round(en[0] * an[0] + en[1] * an[1] + en[2] * an[2]);
    res.v[9] = ic[31:0];
    res.v[10] = is[31:0];
    res.vr = 1'b1;
    return res;
  endfunction

  assign pending = matrix_q.size();

  always @(posedge clk) begin
    logic signed [63:0] a[3], e[3];
    matrix_t want;
    word_t got[11];
    int errs;
    errs = 0;
    if (rst) begin
      min_norm <= THR_RESET;
      matrix_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) min_norm <= cfg_wdata;
      if (sample.valid && sample.ready) begin
        a[0] = sample.grav_x; a[1] = sample.grav_y; a[2] = sample.grav_z;
        e[0] = sample.mag_x;  e[1] = sample.mag_y;  e[2] = sample.mag_z;
        matrix_q.push_back(predict_matrix(a, e, min_norm));
      end
      if (result.valid && result.ready) begin
        if (matrix_q.size() == 0) begin
          $error("result with no item pending");
          errs++;
        end else begin
          want = matrix_q.pop_front();
          got = '{result.rot_00, result.rot_01, result.rot_02, result.rot_10,
                  result.rot_11, result.rot_12, result.rot_20, result.rot_21,
                  result.rot_22, result.incl_cos, result.incl_sin};
          for (int i = 0; i < 11; i++)
            if (got[i] !== want.v[i]) begin
              $error("%s: expected %0d, got %0d", field_name[i], want.v[i], got[i]);
              errs++;
            end
          if (result.valid_res !== want.vr) begin
            $error("valid_res: expected %0b, got %0b", want.vr, result.valid_res);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[bench/testbench.sv]
// testbench top: clock, reset, stimulus, threshold phases and the verdict
`timescale 1ns / 1ps
module testbench;
  import gmr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          hold_req = 0;  // bumped to request one long receiver stall

  gmr_in_if  sample ();
  gmr_out_if result ();

  gravity_magnetic_rotation_matrix_top dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  gmr_checker chk (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall per item, bursts with no stall, and one long hold-off
  initial begin
    int gap;
    int hold_seen;
    hold_seen = 0;
    result.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        result.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
    end
  end

  int quiet_phase = 0;  // sender gaps off for a stretch

  // offer one sample pair and wait until it is taken
  task automatic send_pair(word_t gx, gy, gz, mx, my, mz);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.grav_x <= gx; sample.grav_y <= gy; sample.grav_z <= gz;
    sample.mag_x <= mx; sample.mag_y <= my; sample.mag_z <= mz;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
  endtask

  // wait for every result, let the pipeline drain, then write the threshold
  task automatic drain_and_set(logic [23:0] thr);
    sample.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic word_t rand_comp(int mode);
    case (mode)
      0: return $urandom;                                      // full range
      1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000; // about +-2
      2: return $signed($urandom_range(0, 2047)) - 1024;       // tiny
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // random pairs: mostly sensor-like magnitudes, some full range and extremes
  task automatic random_run(int count);
    int mode;
    word_t c[6];
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      mode = mode < 6 ? 1 : mode < 8 ? 0 : mode < 9 ? 2 : 3;
      foreach (c[j]) c[j] = ($urandom_range(0, 9) == 0) ? rand_comp($urandom_range(0, 3))
                                                          : rand_comp(mode);
      if ($urandom_range(0, 40) == 0) c[$urandom_range(0, 2)] = 0;
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
  endtask

  initial begin
    sample.valid = 1'b0;
    {sample.grav_x, sample.grav_y, sample.grav_z} = '0;
    {sample.mag_x, sample.mag_y, sample.mag_z} = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: axes, zero vectors, parallel vectors, extremes
    send_pair(32'sh10000, 0, 0, 0, 32'sh10000, 0);
    send_pair(0, 0, 32'sh10000, 32'sh8000, 0, -32'sh8000);
    send_pair(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);           // zero gravity
    send_pair(32'sh10000, 32'sh10000, 0, 0, 0, 0);                    // zero magnetic
    send_pair(32'sh10000, 32'sh20000, 32'sh30000, 32'sh20000, 32'sh40000, 32'sh60000);
    send_pair(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh00000001);
    send_pair(1, 0, 0, 0, 1, 0);                                      // tiny H
    send_pair(1, 0, 0, 0, 0, 1);
    send_pair(-1, -1, -1, 1, 0, -1);
    send_pair(32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0);
    send_pair(32'shffffffff, 32'sh1234, -32'sh10000, 32'sh55555555, 32'shaaaaaaaa, 7);
    send_pair(0, 32'sh9c40, 32'sh9c40, 32'sh6000, 0, 0);              // H about 0.32
    send_pair(0, 32'sh1999, 0, 32'sh8000, 0, 0);

    drain_and_set(24'd0);             // threshold zero: only zero H invalid
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(0, 0, 0, 1, 2, 3);
    random_run(300);

    drain_and_set(24'hffffff);        // maximum: nearly all invalid
    send_pair(32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0);
    random_run(150);

    drain_and_set(24'd65536);         // one
    // receiver holds off while the sender keeps offering back to back
    quiet_phase = 1;
    hold_req = hold_req + 1;
    random_run(200);
    quiet_phase = 0;
    // sender pauses until every result is in
    sample.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    random_run(300);

    drain_and_set(24'd6554);
    random_run(300);

    drain_and_set(24'd100);
    quiet_phase = 1;
    random_run(150);
    quiet_phase = 0;
    random_run(200);

    sample.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
